/* rtl/rihd_pkg.sv */
// Shared types and constants for the RLP item header decoder.
// Used by every module under rtl/.
package rihd_pkg;

	localparam logic [7:0] HDR_STR_SHORT  = 8'h80;
	localparam logic [7:0] HDR_STR_LONG   = 8'hb7;
	localparam logic [7:0] HDR_STR_END    = 8'hbf;
	localparam logic [7:0] HDR_LIST_SHORT = 8'hc0;
	localparam logic [7:0] HDR_LIST_LONG  = 8'hf7;
	localparam logic [31:0] LONG_MIN_LEN  = 32'd55;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_TRUNC = 2'd2,
		ST_OOB   = 2'd3
	} status_t;

	typedef struct packed {
		logic        lst;
		logic [3:0]  off;
		logic [31:0] len;
		logic        len_hi;
		logic        canon;
		status_t     status;
		logic        check;
		logic [31:0] room;
	} rec_t;

endpackage

/* rtl/rlp_item_header_decoder.sv */
// Top level of the RLP item header decoder: front end, record queue, back end.
// Depends on rihd_pkg, rihd_front, rihd_queue and rihd_back.
//
// Input channel (in_valid/in_ready): one byte of the encoded stream per transfer;
// item_start marks a header byte and bytes_available is sampled with it.
// Output channel (out_valid/out_ready): one header result per decoded item:
// list flag, header size, content length, canonical flag and status.
// Throughput: one byte per cycle while the record queue has room. The front
// end state machine takes a byte each cycle that in_ready is high; long-form
// length bytes are folded in one per cycle. A result passes the queue write
// and then the output register, which holds the bounds check.
// in_ready is high while the record queue has room; it does not wait for the
// output register, so stalls on the output side reach the input only after
// the output register holds a result and QUEUE_DEPTH records wait behind it.
// Reset clears the phase, the queue and the output valid; no result is lost
// or repeated under any stall pattern.
module rlp_item_header_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        item_start,
	input  logic [31:0] bytes_available,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        list_flag,
	output logic [3:0]  header_size,
	output logic [31:0] content_length,
	output logic        canonical,
	output logic [1:0]  status
);
	import rihd_pkg::*;

	logic q_push, q_pop, q_full, q_empty;
	rec_t q_wdata, q_rdata;

	rihd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.data_byte       (data_byte),
		.item_start      (item_start),
		.bytes_available (bytes_available),
		.q_full          (q_full),
		.push            (q_push),
		.push_data       (q_wdata)
	);

	rihd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.empty     (q_empty)
	);

	rihd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec            (q_rdata),
		.q_empty        (q_empty),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.list_flag      (list_flag),
		.header_size    (header_size),
		.content_length (content_length),
		.canonical      (canonical),
		.status         (status)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("record pushed into full queue");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(!list_flag && !canonical && header_size == 4'd0 && content_length == 32'd0))
		else $error("error result carries nonzero fields");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_size <= 4'd9)
		else $error("header size out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

/* rtl/rihd_front.sv */
// Front end: accepts bytes, classifies headers, gathers long-form lengths.
// Emits one header record per finished item into the queue. Uses rihd_pkg.
module rihd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              item_start,
	input  logic [31:0]       bytes_available,
	input  logic              q_full,
	output logic              push,
	output rihd_pkg::rec_t    push_data
);
	import rihd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_GATHER,
		PH_PEEK
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  left_q, left_n;
	logic [3:0]  width_q, width_n;
	logic [31:0] acc_q, acc_n;
	logic        hi_q, hi_n;
	logic        min_q, min_n;
	logic        list_q, list_n;
	logic [31:0] room_q, room_n;
	logic        fire;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;

	always_comb begin
		logic        lst;
		logic [5:0]  slen;
		logic [3:0]  lw;
		logic [31:0] acc_sh;
		logic        hi_sh;
		logic        min_sh;
		logic [3:0]  left_dec;
		phase_n   = phase_q;
		left_n    = left_q;
		width_n   = width_q;
		acc_n     = acc_q;
		hi_n      = hi_q;
		min_n     = min_q;
		list_n    = list_q;
		room_n    = room_q;
		push      = 1'b0;
		push_data = '0;
		lst       = (data_byte >= HDR_LIST_SHORT);
		slen      = lst ? 6'(data_byte - HDR_LIST_SHORT) : 6'(data_byte - HDR_STR_SHORT);
		lw        = (data_byte > HDR_LIST_LONG) ? 4'(data_byte - HDR_LIST_LONG)
		                                        : 4'(data_byte - HDR_STR_LONG);
		acc_sh    = {acc_q[23:0], data_byte};
		hi_sh     = hi_q | (acc_q[31:24] != 8'd0);
		min_sh    = (left_q == width_q) ? (data_byte != 8'd0) : min_q;
		left_dec  = left_q - 4'd1;
		if (item_start) begin
			phase_n = PH_IDLE;
			left_n  = '0;
			width_n = '0;
			acc_n   = '0;
			hi_n    = 1'b0;
			min_n   = 1'b0;
			list_n  = 1'b0;
			room_n  = bytes_available;
			if (bytes_available == 32'd0) begin
				push             = 1'b1;
				push_data.status = ST_EMPTY;
			end else if (data_byte < HDR_STR_SHORT) begin
				push            = 1'b1;
				push_data.len   = 32'd1;
				push_data.canon = 1'b1;
			end else if (data_byte <= HDR_STR_LONG ||
			             (lst && data_byte <= HDR_LIST_LONG)) begin
				if (!lst && slen == 6'd1 && bytes_available != 32'd1) begin
					phase_n = PH_PEEK;
				end else begin
					push            = 1'b1;
					push_data.lst   = lst;
					push_data.off   = 4'd1;
					push_data.len   = 32'(slen);
					push_data.canon = 1'b1;
					push_data.check = 1'b1;
					push_data.room  = bytes_available;
				end
			end else begin
				list_n  = lst;
				width_n = lw;
				if ((bytes_available - 32'd1) < 32'(lw)) begin
					push             = 1'b1;
					push_data.status = ST_TRUNC;
				end else begin
					left_n  = lw;
					phase_n = PH_GATHER;
				end
			end
		end else begin
			unique case (phase_q)
				PH_PEEK: begin
					phase_n         = PH_IDLE;
					push            = 1'b1;
					push_data.off   = 4'd1;
					push_data.len   = 32'd1;
					push_data.canon = data_byte[7];
				end
				PH_GATHER: begin
					acc_n  = acc_sh;
					hi_n   = hi_sh;
					min_n  = min_sh;
					left_n = left_dec;
					if (left_dec == 4'd0) begin
						phase_n         = PH_IDLE;
						push            = 1'b1;
						push_data.lst   = list_q;
						push_data.off   = 4'd1 + width_q;
						push_data.len   = acc_sh;
						push_data.len_hi = hi_sh;
						push_data.canon = min_sh && (hi_sh || acc_sh > LONG_MIN_LEN);
						push_data.check = 1'b1;
						push_data.room  = room_q;
					end
				end
				default: begin
				end
			endcase
		end
		push = push && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= '0;
			width_q <= '0;
			acc_q   <= '0;
			hi_q    <= 1'b0;
			min_q   <= 1'b0;
			list_q  <= 1'b0;
			room_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			left_q  <= left_n;
			width_q <= width_n;
			acc_q   <= acc_n;
			hi_q    <= hi_n;
			min_q   <= min_n;
			list_q  <= list_n;
			room_q  <= room_n;
		end
	end

endmodule

/* rtl/rihd_queue.sv */
// Short register queue of header records between front and back end.
// Uses rihd_pkg for the record type.
module rihd_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rihd_pkg::rec_t push_data,
	output logic           full,
	input  logic           pop,
	output rihd_pkg::rec_t pop_data,
	output logic           empty
);
	import rihd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/rihd_back.sv */
// Back end: bounds check of a header record and the registered result item.
// Uses rihd_pkg.
module rihd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rihd_pkg::rec_t rec,
	input  logic           q_empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           list_flag,
	output logic [3:0]     header_size,
	output logic [31:0]    content_length,
	output logic           canonical,
	output logic [1:0]     status
);
	import rihd_pkg::*;

	logic        valid_q;
	logic        lst_q;
	logic [3:0]  off_q;
	logic [31:0] len_q;
	logic        canon_q;
	status_t     st_q;
	status_t     st_n;
	logic [32:0] end_pos;

	assign pop     = !q_empty && (!valid_q || out_ready);
	assign end_pos = {1'b0, rec.len} + 33'(rec.off);

	always_comb begin
		st_n = rec.status;
		if (rec.check && (rec.len_hi || end_pos > {1'b0, rec.room})) begin
			st_n = ST_OOB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			st_q <= st_n;
			if (st_n == ST_OK) begin
				lst_q   <= rec.lst;
				off_q   <= rec.off;
				len_q   <= rec.len;
				canon_q <= rec.canon;
			end else begin
				lst_q   <= 1'b0;
				off_q   <= '0;
				len_q   <= '0;
				canon_q <= 1'b0;
			end
		end
	end

	assign out_valid      = valid_q;
	assign list_flag      = lst_q;
	assign header_size    = off_q;
	assign content_length = len_q;
	assign canonical      = canon_q;
	assign status         = st_q;

endmodule
